FILE: hw/rtl/sphd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphd_pkg
// Shared types and constants for the spatial hash point dedup block.
// ----------------------------------------------------------------------------
package sphd_pkg;

  localparam int BUCKET_COUNT        = 1024;
  localparam int NODE_POOL_DEPTH     = 4096;
  localparam int COORD_FRACTION_BITS = 6;

  localparam int BUCKET_BITS = $clog2(BUCKET_COUNT);
  localparam int POOL_BITS   = $clog2(NODE_POOL_DEPTH);
  localparam int CNT_BITS    = POOL_BITS + 1;
  localparam int COORD_W     = 24;
  localparam int TOL_W       = 8;
  localparam int SHIFT_W     = 4;

  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 8'd7;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(COORD_FRACTION_BITS + 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL   = CNT_BITS'(NODE_POOL_DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic {
    REG_TOL   = 1'b0,
    REG_SHIFT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_BKT,
    S_BKT_WAIT,
    S_NODE_WAIT,
    S_WRITE,
    S_READ,
    S_RD_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 vld;
    logic [POOL_BITS-1:0] head;
  } bucket_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      link_vld;
    logic [POOL_BITS-1:0]      link;
  } node_t;

  typedef struct packed {
    logic [BUCKET_BITS-1:0] bkt_rd_addr;
    logic                   bkt_we;
    logic [BUCKET_BITS-1:0] bkt_wr_addr;
    bucket_t                bkt_wdata;
    logic [POOL_BITS-1:0]   node_addr;
    logic                   node_we;
    node_t                  node_wdata;
  } store_req_t;

endpackage

FILE: hw/rtl/spatial_hash_point_dedup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_hash_point_dedup
// Point set deduplicator on a grid hash with chained buckets in a node pool.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. Insert and find walk the bucket chain
// one node at a time through the single-port node memory, and insert adds a
// write step. Clear, and the start-up after reset, sweep the bucket head
// memory one entry a cycle over all 1024 entries, during which no item is
// accepted. Configuration writes are taken in any cycle. A finished result
// sits in an output register, so the next item may be accepted while it
// waits.
module spatial_hash_point_dedup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // x_coord[23:0], y_coord[47:24], entry_index[59:48]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // stored_count[12:0], entry_x[36:13], entry_y[60:37]
  output logic [2:0]  out_tuser,  // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import sphd_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic signed [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [POOL_BITS-1:0]   idx_r, idx_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic [TOL_W-1:0]       tol_r;
  logic [SHIFT_W-1:0]     shift_r;
  bucket_t                bkt_r, bkt_nxt;
  logic [BUCKET_BITS-1:0] clr_r, clr_nxt;
  logic                   clr_rsp_r, clr_rsp_nxt;
  status_t                res_status_r, res_status_nxt;
  logic signed [COORD_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [CNT_BITS-1:0]    out_count_r, out_count_nxt;
  logic signed [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic [BUCKET_BITS-1:0] bucket;
  store_req_t req;
  bucket_t    bkt_rdata;
  node_t      node_rdata;
  logic       in_acc, out_free, match;
  logic [COORD_W:0] dx, dy, ax, ay;

  sphd_hash u_hash (
    .clk        (clk),
    .x_coord    (x_r),
    .y_coord    (y_r),
    .cell_shift (shift_r),
    .bucket     (bucket)
  );

  sphd_store u_store (
    .clk        (clk),
    .req        (req),
    .bkt_rdata  (bkt_rdata),
    .node_rdata (node_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // tolerance compare on the node just read
  always_comb begin
    dx = {node_rdata.x[COORD_W-1], node_rdata.x} - {x_r[COORD_W-1], x_r};
    dy = {node_rdata.y[COORD_W-1], node_rdata.y} - {y_r[COORD_W-1], y_r};
    ax = dx[COORD_W] ? -dx : dx;
    ay = dy[COORD_W] ? -dy : dy;
    match = (ax < {{(COORD_W+1-TOL_W){1'b0}}, tol_r}) &&
            (ay < {{(COORD_W+1-TOL_W){1'b0}}, tol_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_r == BUCKET_BITS'(BUCKET_COUNT - 1)) begin
          state_nxt = clr_rsp_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_tuser))
            OP_CLEAR: state_nxt = S_CLR;
            OP_READ:  state_nxt = S_READ;
            default:  state_nxt = S_HASH1;
          endcase
        end
      end
      S_HASH1:    state_nxt = S_HASH2;
      S_HASH2:    state_nxt = S_BKT;
      S_BKT:      state_nxt = S_BKT_WAIT;
      S_BKT_WAIT: begin
        if (bkt_rdata.vld) begin
          state_nxt = S_NODE_WAIT;
        end else begin
          state_nxt = (op_r == OP_INSERT) ? S_WRITE : S_DONE;
        end
      end
      S_NODE_WAIT: begin
        if (match) begin
          state_nxt = S_DONE;
        end else if (!node_rdata.link_vld) begin
          state_nxt = (op_r == OP_INSERT) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE:   state_nxt = S_DONE;
      S_READ:    state_nxt = S_RD_WAIT;
      S_RD_WAIT: state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    op_nxt         = op_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    bkt_nxt        = bkt_r;
    clr_nxt        = clr_r;
    clr_rsp_nxt    = clr_rsp_r;
    res_status_nxt = res_status_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;

    req             = '0;
    req.bkt_rd_addr = bucket;
    req.bkt_wr_addr = clr_r;
    req.node_addr   = idx_r;
    req.node_wdata  = '{x: x_r, y: y_r, link_vld: bkt_r.vld, link: bkt_r.head};

    unique case (state_r)
      S_CLR: begin
        req.bkt_we    = 1'b1;
        req.bkt_wdata = '0;
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == BUCKET_BITS'(BUCKET_COUNT - 1)) begin
          count_nxt = '0;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = op_t'(in_tuser);
          x_nxt          = in_tdata[COORD_W-1:0];
          y_nxt          = in_tdata[2*COORD_W-1:COORD_W];
          idx_nxt        = in_tdata[2*COORD_W +: POOL_BITS];
          clr_nxt        = '0;
          clr_rsp_nxt    = 1'b1;
          res_status_nxt = ST_DONE;
          res_x_nxt      = '0;
          res_y_nxt      = '0;
        end
      end
      S_BKT_WAIT: begin
        bkt_nxt        = bkt_rdata;
        req.node_addr  = bkt_rdata.head;
        res_status_nxt = (op_r == OP_INSERT) ? ST_DONE : ST_NOT_FOUND;
      end
      S_NODE_WAIT: begin
        req.node_addr = node_rdata.link;
        if (match) begin
          res_status_nxt = ST_PRESENT;
        end
      end
      S_WRITE: begin
        if (count_r == CNT_FULL) begin
          res_status_nxt = ST_FULL;
        end else begin
          req.node_addr   = count_r[POOL_BITS-1:0];
          req.node_we     = 1'b1;
          req.bkt_we      = 1'b1;
          req.bkt_wr_addr = bucket;
          req.bkt_wdata   = '{vld: 1'b1, head: count_r[POOL_BITS-1:0]};
          count_nxt       = count_r + 1'b1;
        end
      end
      S_RD_WAIT: begin
        if ({1'b0, idx_r} < count_r) begin
          res_x_nxt = node_rdata.x;
          res_y_nxt = node_rdata.y;
        end else begin
          res_status_nxt = ST_RANGE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_r;
          out_x_nxt      = res_x_r;
          out_y_nxt      = res_y_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clr_rsp_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      tol_r       <= TOL_RESET;
      shift_r     <= SHIFT_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_TOL:   tol_r   <= cfg_data;
          REG_SHIFT: shift_r <= cfg_data[SHIFT_W-1:0];
          default:   tol_r   <= tol_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    idx_r        <= idx_nxt;
    bkt_r        <= bkt_nxt;
    res_status_r <= res_status_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_y_r, out_x_r, out_count_r};

endmodule

FILE: hw/rtl/sphd_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphd_hash
// Two-stage bucket index: cell indices, then prime multiply and XOR.
// ----------------------------------------------------------------------------
module sphd_hash (
  input  logic                                clk,
  input  logic signed [sphd_pkg::COORD_W-1:0] x_coord,
  input  logic signed [sphd_pkg::COORD_W-1:0] y_coord,
  input  logic [sphd_pkg::SHIFT_W-1:0]        cell_shift,
  output logic [sphd_pkg::BUCKET_BITS-1:0]    bucket
);
  import sphd_pkg::*;

  logic [BUCKET_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt, bucket_r, bucket_nxt;
  logic [2*BUCKET_BITS-1:0] px, py;

  // Truncate toward zero: shift the magnitude, then restore the sign.
  function automatic logic [BUCKET_BITS-1:0] cell_of(input logic signed [COORD_W-1:0] c,
                                                     input logic [SHIFT_W-1:0] s);
    logic [COORD_W:0] mag;
    logic [COORD_W:0] sh;
    mag = c[COORD_W-1] ? (COORD_W+1)'(-{c[COORD_W-1], c}) : {1'b0, c};
    sh  = mag >> s;
    return c[COORD_W-1] ? BUCKET_BITS'(-sh) : sh[BUCKET_BITS-1:0];
  endfunction

  always_comb begin
    cx_nxt = cell_of(x_coord, cell_shift);
    cy_nxt = cell_of(y_coord, cell_shift);
    // only the low bits of each product reach the mask
    px = cx_r * PRIME_X[BUCKET_BITS-1:0];
    py = cy_r * PRIME_Y[BUCKET_BITS-1:0];
    bucket_nxt = px[BUCKET_BITS-1:0] ^ py[BUCKET_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    bucket_r <= bucket_nxt;
  end

  assign bucket = bucket_r;

endmodule

FILE: hw/rtl/sphd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphd_store
// Bucket head memory and node pool memory, registered reads.
// ----------------------------------------------------------------------------
module sphd_store (
  input  logic                 clk,
  input  sphd_pkg::store_req_t req,
  output sphd_pkg::bucket_t    bkt_rdata,
  output sphd_pkg::node_t      node_rdata
);
  import sphd_pkg::*;

  bucket_t bkt_mem [BUCKET_COUNT];
  node_t   node_mem [NODE_POOL_DEPTH];
  bucket_t bkt_rdata_r;
  node_t   node_rdata_r;

  always_ff @(posedge clk) begin
    if (req.bkt_we) begin
      bkt_mem[req.bkt_wr_addr] <= req.bkt_wdata;
    end
    bkt_rdata_r <= bkt_mem[req.bkt_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.node_we) begin
      node_mem[req.node_addr] <= req.node_wdata;
    end
    node_rdata_r <= node_mem[req.node_addr];
  end

  assign bkt_rdata  = bkt_rdata_r;
  assign node_rdata = node_rdata_r;

endmodule
